FILE: sv/dce_pkg.sv
`timescale 1ns / 1ps
package dce_pkg;

  localparam int SENSOR_COUNT    = 16;
  localparam int ROTATION_STAGES = 16;
  localparam int ATAN_LEN        = 24;
  localparam int SENSOR_SLOTS    = 16;
  localparam int PIPE_DEPTH      = ROTATION_STAGES + 7;

  localparam int FULL_TURN_I = 46080;

  localparam logic [15:0] FULL_TURN    = 16'd46080;
  localparam logic [15:0] QUARTER_TURN = 16'd11520;
  localparam logic [15:0] HALF_TURN    = 16'd23040;
  localparam logic [15:0] THREE_QUARTER_TURN = 16'd34560;

  localparam logic [32:0] RAD_PER_UNIT = 33'd146409;
  localparam logic signed [32:0] GAIN_INV = 33'sd652032874;
  localparam logic signed [18:0] EDGE_MAX = 19'sh3FFFF;
  localparam logic signed [18:0] EDGE_MIN = -19'sh40000;

  typedef logic [$clog2(ATAN_LEN)-1:0] stage_idx_t;
  typedef logic [15:0]                 angle_t;
  typedef logic [17:0]                 dist_t;
  typedef logic [18:0]                 radius_t;
  typedef logic [17:0]                 half_width_t;
  typedef logic signed [32:0]          vec_t;
  typedef logic signed [18:0]          edge_t;
  typedef logic [$clog2(PIPE_DEPTH+1)-1:0] occ_t;

  typedef logic signed [32:0] atan_rom_t [ATAN_LEN];
  typedef angle_t             offset_rom_t [SENSOR_SLOTS];

  localparam atan_rom_t ATAN_TABLE = '{
    33'sd843314856, 33'sd497837829, 33'sd263043836, 33'sd133525158,
    33'sd67021686,  33'sd33543515,  33'sd16775850,  33'sd8388437,
    33'sd4194282,   33'sd2097149,   33'sd1048575,   33'sd524287,
    33'sd262143,    33'sd131071,    33'sd65535,     33'sd32767,
    33'sd16383,     33'sd8191,      33'sd4095,      33'sd2047,
    33'sd1023,      33'sd511,       33'sd255,       33'sd127
  };

  // Sensor mounting angle in 1/128 degree, rounded and folded into one turn.
  function automatic offset_rom_t make_offset_rom();
    offset_rom_t rom;
    int          v;
    for (int i = 0; i < SENSOR_SLOTS; i++) begin
      v = (i * FULL_TURN_I + SENSOR_COUNT / 2) / SENSOR_COUNT;
      v = v % FULL_TURN_I;
      rom[i] = angle_t'(v);
    end
    return rom;
  endfunction

  localparam offset_rom_t OFFSET_ROM = make_offset_rom();

  typedef struct packed {
    logic [9:0]  distance_step;
    logic [11:0] turret_radius;
    logic [15:0] cone_tangent;
  } cfg_t;

  typedef struct packed {
    vec_t        x;
    vec_t        y;
    vec_t        z;
    logic [1:0]  quad;
    radius_t     r;
    half_width_t w;
  } beat_t;

endpackage

FILE: sv/dce_in_if.sv
`timescale 1ns / 1ps
interface dce_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  sensor_index;
  logic [7:0]  range_count;
  logic [15:0] heading;

  modport source (output valid, sensor_index, range_count, heading, input ready);
  modport sink (input valid, sensor_index, range_count, heading, output ready);
endinterface

FILE: sv/dce_out_if.sv
`timescale 1ns / 1ps
interface dce_out_if;
  logic          valid;
  logic          ready;
  dce_pkg::edge_t edge_a_x;
  dce_pkg::edge_t edge_a_y;
  dce_pkg::edge_t edge_b_x;
  dce_pkg::edge_t edge_b_y;

  modport source (output valid, edge_a_x, edge_a_y, edge_b_x, edge_b_y, input ready);
  modport sink (input valid, edge_a_x, edge_a_y, edge_b_x, edge_b_y, output ready);
endinterface

FILE: sv/detection_cone_endpoints_unit.sv
`timescale 1ns / 1ps
// Channel   Role      Beat contents
// reading   sink      sensor_index, range_count, heading
// result    source    edge_a_x, edge_a_y, edge_b_x, edge_b_y
// apb       target    distance_step (0x0), turret_radius (0x4), cone_tangent (0x8)
//
// One reading per clock cycle while the result is taken; the path is four front
// stages, one rotation cell per stage and three stages for quadrant, products and sums.
// Synchronous reset empties every stage and loads the register defaults.
// Each stage holds its beat only while the next one is full and stalled, so bubbles
// collapse and readings keep entering while a result waits at the output.
module detection_cone_endpoints_unit (
  input  logic        clk,
  input  logic        rst,
  dce_in_if.sink      reading,
  dce_out_if.source   result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [1:0] REG_DISTANCE_STEP = 2'd0;
  localparam logic [1:0] REG_TURRET_RADIUS = 2'd1;
  localparam logic [1:0] REG_CONE_TANGENT  = 2'd2;

  dce_pkg::cfg_t  cfg;
  dce_pkg::occ_t  occupancy;

  logic           chain_valid [dce_pkg::ROTATION_STAGES+1];
  logic           chain_ready [dce_pkg::ROTATION_STAGES+1];
  dce_pkg::beat_t chain_beat  [dce_pkg::ROTATION_STAGES+1];

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.distance_step <= 10'd410;
      cfg.turret_radius <= 12'd1229;
      cfg.cone_tangent  <= 16'd15130;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_DISTANCE_STEP: cfg.distance_step <= pwdata[9:0];
        REG_TURRET_RADIUS: cfg.turret_radius <= pwdata[11:0];
        REG_CONE_TANGENT:  cfg.cone_tangent  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_DISTANCE_STEP: prdata = {22'd0, cfg.distance_step};
      REG_TURRET_RADIUS: prdata = {20'd0, cfg.turret_radius};
      REG_CONE_TANGENT:  prdata = {16'd0, cfg.cone_tangent};
      default:           prdata = '0;
    endcase
  end

  dce_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .in_valid     (reading.valid),
    .in_ready     (reading.ready),
    .sensor_index (reading.sensor_index),
    .range_count  (reading.range_count),
    .heading      (reading.heading),
    .out_valid    (chain_valid[0]),
    .out_ready    (chain_ready[0]),
    .out_beat     (chain_beat[0])
  );

  for (genvar g = 0; g < dce_pkg::ROTATION_STAGES; g++) begin : g_cell
    dce_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .stage     (dce_pkg::stage_idx_t'(g)),
      .in_valid  (chain_valid[g]),
      .in_ready  (chain_ready[g]),
      .in_beat   (chain_beat[g]),
      .out_valid (chain_valid[g+1]),
      .out_ready (chain_ready[g+1]),
      .out_beat  (chain_beat[g+1])
    );
  end

  dce_back u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (chain_valid[dce_pkg::ROTATION_STAGES]),
    .in_ready  (chain_ready[dce_pkg::ROTATION_STAGES]),
    .in_beat   (chain_beat[dce_pkg::ROTATION_STAGES]),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .edge_a_x  (result.edge_a_x),
    .edge_a_y  (result.edge_a_y),
    .edge_b_x  (result.edge_b_x),
    .edge_b_y  (result.edge_b_y)
  );

  // Beats inside the unit, counted at the ports.
  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy <= '0;
    end else begin
      case ({reading.valid && reading.ready, result.valid && result.ready})
        2'b10:   occupancy <= occupancy + dce_pkg::occ_t'(1);
        2'b01:   occupancy <= occupancy - dce_pkg::occ_t'(1);
        default: occupancy <= occupancy;
      endcase
    end
  end

  a_empty_after_reset: assert property (@(posedge clk) $past(rst) |-> !result.valid)
    else $error("result valid right after reset");

  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    (!result.valid || result.ready) |-> reading.ready)
    else $error("input stalled although the output can move");

  a_result_has_source: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> occupancy != '0)
    else $error("result offered with no reading inside");

  a_occupancy_bound: assert property (@(posedge clk) disable iff (rst)
    occupancy <= dce_pkg::occ_t'(dce_pkg::PIPE_DEPTH))
    else $error("more beats inside than pipeline stages");

endmodule

FILE: sv/dce_front.sv
`timescale 1ns / 1ps
module dce_front (
  input  logic          clk,
  input  logic          rst,
  input  dce_pkg::cfg_t cfg,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [3:0]    sensor_index,
  input  logic [7:0]    range_count,
  input  logic [15:0]   heading,
  output logic          out_valid,
  input  logic          out_ready,
  output dce_pkg::beat_t out_beat
);

  logic v1, v2, v3, v4;
  logic en1, en2, en3, en4;

  dce_pkg::angle_t head1, offs1;
  dce_pkg::dist_t  d1;
  dce_pkg::angle_t angle2;
  dce_pkg::radius_t r2, r3;
  logic [33:0]      wprod2;
  logic [1:0]       quad3;
  logic [13:0]      rem3;
  dce_pkg::half_width_t w3;

  logic [16:0]      angle_sum;
  dce_pkg::angle_t  head_mod;

  assign en4 = !v4 || out_ready;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign in_ready  = en1;
  assign out_valid = v4;

  assign head_mod  = (heading >= dce_pkg::FULL_TURN) ? heading - dce_pkg::FULL_TURN : heading;
  assign angle_sum = {1'b0, head1} + {1'b0, offs1};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      head1 <= head_mod;
      offs1 <= dce_pkg::OFFSET_ROM[sensor_index];
      d1    <= dce_pkg::dist_t'(range_count) * dce_pkg::dist_t'(cfg.distance_step);
    end
    if (en2) begin
      angle2 <= (angle_sum >= {1'b0, dce_pkg::FULL_TURN}) ?
                dce_pkg::angle_t'(angle_sum - {1'b0, dce_pkg::FULL_TURN}) :
                dce_pkg::angle_t'(angle_sum);
      r2     <= dce_pkg::radius_t'(cfg.turret_radius) + dce_pkg::radius_t'(d1);
      wprod2 <= 34'(d1) * 34'(cfg.cone_tangent);
    end
    if (en3) begin
      if (angle2 >= dce_pkg::THREE_QUARTER_TURN) begin
        quad3 <= 2'd3;
        rem3  <= 14'(angle2 - dce_pkg::THREE_QUARTER_TURN);
      end else if (angle2 >= dce_pkg::HALF_TURN) begin
        quad3 <= 2'd2;
        rem3  <= 14'(angle2 - dce_pkg::HALF_TURN);
      end else if (angle2 >= dce_pkg::QUARTER_TURN) begin
        quad3 <= 2'd1;
        rem3  <= 14'(angle2 - dce_pkg::QUARTER_TURN);
      end else begin
        quad3 <= 2'd0;
        rem3  <= 14'(angle2);
      end
      r3 <= r2;
      // Round the half width to nearest, ties up.
      w3 <= dce_pkg::half_width_t'((wprod2 + 34'd32768) >> 16);
    end
    if (en4) begin
      out_beat.x    <= dce_pkg::GAIN_INV;
      out_beat.y    <= '0;
      out_beat.z    <= dce_pkg::vec_t'(33'(rem3) * dce_pkg::RAD_PER_UNIT);
      out_beat.quad <= quad3;
      out_beat.r    <= r3;
      out_beat.w    <= w3;
    end
  end

endmodule

FILE: sv/dce_cell.sv
`timescale 1ns / 1ps
module dce_cell (
  input  logic                clk,
  input  logic                rst,
  input  dce_pkg::stage_idx_t stage,
  input  logic                in_valid,
  output logic                in_ready,
  input  dce_pkg::beat_t      in_beat,
  output logic                out_valid,
  input  logic                out_ready,
  output dce_pkg::beat_t      out_beat
);

  logic           valid;
  logic           en;
  dce_pkg::vec_t  dx, dy, step_angle;
  dce_pkg::beat_t rot;

  assign en        = !valid || out_ready;
  assign in_ready  = en;
  assign out_valid = valid;

  assign dx         = in_beat.y >>> stage;
  assign dy         = in_beat.x >>> stage;
  assign step_angle = dce_pkg::ATAN_TABLE[stage];

  always_comb begin
    rot = in_beat;
    if (!in_beat.z[32]) begin
      rot.x = in_beat.x - dx;
      rot.y = in_beat.y + dy;
      rot.z = in_beat.z - step_angle;
    end else begin
      rot.x = in_beat.x + dx;
      rot.y = in_beat.y - dy;
      rot.z = in_beat.z + step_angle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_beat <= rot;
    end
  end

endmodule

FILE: sv/dce_back.sv
`timescale 1ns / 1ps
module dce_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  dce_pkg::beat_t in_beat,
  output logic           out_valid,
  input  logic           out_ready,
  output dce_pkg::edge_t edge_a_x,
  output dce_pkg::edge_t edge_a_y,
  output dce_pkg::edge_t edge_b_x,
  output dce_pkg::edge_t edge_b_y
);

  localparam logic signed [53:0] ROUND_HALF = 54'sd536870912;

  logic v1, v2, v3;
  logic en1, en2, en3;

  dce_pkg::vec_t        co1, si1;
  dce_pkg::radius_t     r1;
  dce_pkg::half_width_t w1;
  logic signed [52:0]   rc2, rs2, ws2, wc2;
  dce_pkg::vec_t        co_q, si_q;

  function automatic dce_pkg::edge_t saturate(input logic signed [53:0] sum);
    logic signed [23:0] t;
    t = 24'(sum >>> 30);
    if (t > 24'(dce_pkg::EDGE_MAX)) begin
      return dce_pkg::EDGE_MAX;
    end else if (t < 24'(dce_pkg::EDGE_MIN)) begin
      return dce_pkg::EDGE_MIN;
    end
    return dce_pkg::edge_t'(t);
  endfunction

  // Fold the first-quadrant rotation back into the full circle.
  always_comb begin
    case (in_beat.quad)
      2'd0: begin
        co_q = in_beat.x;
        si_q = in_beat.y;
      end
      2'd1: begin
        co_q = -in_beat.y;
        si_q = in_beat.x;
      end
      2'd2: begin
        co_q = -in_beat.x;
        si_q = -in_beat.y;
      end
      default: begin
        co_q = in_beat.y;
        si_q = -in_beat.x;
      end
    endcase
  end

  assign en3 = !v3 || out_ready;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign in_ready  = en1;
  assign out_valid = v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      co1 <= co_q;
      si1 <= si_q;
      r1  <= in_beat.r;
      w1  <= in_beat.w;
    end
    if (en2) begin
      rc2 <= 53'($signed({1'b0, r1})) * 53'(co1);
      rs2 <= 53'($signed({1'b0, r1})) * 53'(si1);
      ws2 <= 53'($signed({1'b0, w1})) * 53'(si1);
      wc2 <= 53'($signed({1'b0, w1})) * 53'(co1);
    end
    if (en3) begin
      edge_a_x <= saturate(54'(rc2) + 54'(ws2) + ROUND_HALF);
      edge_a_y <= saturate(54'(rs2) - 54'(wc2) + ROUND_HALF);
      edge_b_x <= saturate(54'(rc2) - 54'(ws2) + ROUND_HALF);
      edge_b_y <= saturate(54'(rs2) + 54'(wc2) + ROUND_HALF);
    end
  end

endmodule

FILE: tb/dce_tb_pkg.sv
`timescale 1ns / 1ps
package dce_tb_pkg;

  // Register map of the configuration port.
  localparam logic [3:0] ADDR_DISTANCE_STEP = 4'h0;
  localparam logic [3:0] ADDR_TURRET_RADIUS = 4'h4;
  localparam logic [3:0] ADDR_CONE_TANGENT  = 4'h8;
  localparam logic [3:0] ADDR_UNMAPPED      = 4'hC;

endpackage

FILE: tb/dce_cone_checker.sv
`timescale 1ns / 1ps
module dce_cone_checker (
  input  logic        clk,
  input  logic        rst,
  dce_in_if           reading,
  dce_out_if          result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output int          fail_count,
  output int          outstanding
);

  localparam int unsigned TURN_UNITS     = 46080;
  localparam int unsigned QUADRANT_UNITS = 11520;
  localparam int unsigned SENSORS        = 16;
  localparam int          STAGES         = 16;

  localparam longint STEP_RESET    = 410;
  localparam longint RADIUS_RESET  = 1229;
  localparam longint TANGENT_RESET = 15130;

  localparam longint RAD_PER_UNIT_Q30 = 146409;
  localparam longint START_X_Q30      = 652032874;
  localparam longint ROUND_HALF_Q30   = 64'sd536870912;
  localparam longint EDGE_HI          = 262143;
  localparam longint EDGE_LO          = -262144;

  localparam longint ARCTAN_Q30 [24] = '{
    843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
    16775850, 8388437, 4194282, 2097149, 1048575, 524287,
    262143, 131071, 65535, 32767, 16383, 8191,
    4095, 2047, 1023, 511, 255, 127
  };

  typedef struct packed {
    dce_pkg::edge_t a_x;
    dce_pkg::edge_t a_y;
    dce_pkg::edge_t b_x;
    dce_pkg::edge_t b_y;
  } cone_edges_t;

  longint      step_q8;
  longint      radius_q8;
  longint      tangent_q16;
  int          errors = 0;
  cone_edges_t pending_edges [$];
  cone_edges_t want;

  function automatic dce_pkg::edge_t clamp_edge(input longint v);
    if (v > EDGE_HI) v = EDGE_HI;
    else if (v < EDGE_LO) v = EDGE_LO;
    return v[18:0];
  endfunction

  function automatic cone_edges_t predict_edges(input logic [3:0] idx, input logic [7:0] cnt,
                                                input logic [15:0] hdg);
    int unsigned hdg_u, idx_u, beam, quad;
    longint      span, reach, half_w, x, y, z, dx, dy, c, s;
    int          i;
    cone_edges_t e;
    hdg_u = 32'(hdg);
    idx_u = 32'(idx);
    beam  = (hdg_u % TURN_UNITS + (idx_u * TURN_UNITS + SENSORS / 2) / SENSORS) % TURN_UNITS;
    quad  = beam / QUADRANT_UNITS;
    z     = longint'(beam % QUADRANT_UNITS) * RAD_PER_UNIT_Q30;
    x     = START_X_Q30;
    y     = 0;
    // Rotation toward z with floor shifts; the start vector already carries the gain.
    for (i = 0; i < STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - ARCTAN_Q30[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + ARCTAN_Q30[i];
      end
    end
    case (quad)
      0: begin
        c = x;
        s = y;
      end
      1: begin
        c = -y;
        s = x;
      end
      2: begin
        c = -x;
        s = -y;
      end
      default: begin
        c = y;
        s = -x;
      end
    endcase
    span   = longint'(cnt) * step_q8;
    reach  = radius_q8 + span;
    half_w = (span * tangent_q16 + 32768) >>> 16;
    e.a_x  = clamp_edge((reach * c + half_w * s + ROUND_HALF_Q30) >>> 30);
    e.a_y  = clamp_edge((reach * s - half_w * c + ROUND_HALF_Q30) >>> 30);
    e.b_x  = clamp_edge((reach * c - half_w * s + ROUND_HALF_Q30) >>> 30);
    e.b_y  = clamp_edge((reach * s + half_w * c + ROUND_HALF_Q30) >>> 30);
    return e;
  endfunction

  task automatic compare_field(input string name, input dce_pkg::edge_t exp_v,
                               input dce_pkg::edge_t got_v);
    if (exp_v !== got_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      step_q8     = STEP_RESET;
      radius_q8   = RADIUS_RESET;
      tangent_q16 = TANGENT_RESET;
      pending_edges.delete();
    end else begin
      if (result.valid && result.ready) begin
        if (pending_edges.size() == 0) begin
          errors++;
          $display("%0t: unexpected result beat, got a (%0d, %0d) b (%0d, %0d)", $time,
                   result.edge_a_x, result.edge_a_y, result.edge_b_x, result.edge_b_y);
        end else begin
          want = pending_edges.pop_front();
          compare_field("edge_a_x", want.a_x, result.edge_a_x);
          compare_field("edge_a_y", want.a_y, result.edge_a_y);
          compare_field("edge_b_x", want.b_x, result.edge_b_x);
          compare_field("edge_b_y", want.b_y, result.edge_b_y);
        end
      end
      if (reading.valid && reading.ready)
        pending_edges.push_back(predict_edges(reading.sensor_index, reading.range_count,
                                              reading.heading));
      if (psel && penable && pwrite && pready) begin
        case (paddr)
          dce_tb_pkg::ADDR_DISTANCE_STEP: step_q8     = longint'(pwdata[9:0]);
          dce_tb_pkg::ADDR_TURRET_RADIUS: radius_q8   = longint'(pwdata[11:0]);
          dce_tb_pkg::ADDR_CONE_TANGENT:  tangent_q16 = longint'(pwdata[15:0]);
          default: ;
        endcase
      end
    end
    fail_count  <= errors;
    outstanding <= pending_edges.size();
  end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;

  localparam int HOLD_CYCLES  = 120;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = dce_pkg::PIPE_DEPTH + 10;

  logic        clk = 1'b0;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        hold_req;
  logic        active;
  int          fail_count;
  int          outstanding;

  dce_in_if  reading ();
  dce_out_if result ();

  detection_cone_endpoints_unit uut (
    .clk     (clk),
    .rst     (rst),
    .reading (reading),
    .result  (result),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  dce_cone_checker chk (
    .clk         (clk),
    .rst         (rst),
    .reading     (reading),
    .result      (result),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always #6 clk = ~clk;

  assign active = (reading.valid && reading.ready) || (result.valid && result.ready) ||
                  (psel && penable);

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic offer_reading(input logic [3:0] idx, input logic [7:0] cnt,
                               input logic [15:0] hdg, input int gap);
    if (gap > 0) begin
      reading.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    reading.valid        <= 1'b1;
    reading.sensor_index <= idx;
    reading.range_count  <= cnt;
    reading.heading      <= hdg;
    @(posedge clk);
    while (!reading.ready) @(posedge clk);
  endtask

  // Ends with a quiet cycle so that back-to-back writes never touch psel twice in one step.
  task automatic apb_write(input logic [3:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_settings(input logic [31:0] step_word, input logic [31:0] radius_word,
                               input logic [31:0] tangent_word);
    apb_write(dce_tb_pkg::ADDR_DISTANCE_STEP, step_word);
    apb_write(dce_tb_pkg::ADDR_TURRET_RADIUS, radius_word);
    apb_write(dce_tb_pkg::ADDR_CONE_TANGENT, tangent_word);
  endtask

  task automatic drain();
    reading.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic run_random(input int count, input bit squeeze);
    int          n;
    int          gap;
    logic [7:0]  cnt;
    logic [15:0] hdg;
    for (n = 0; n < count; n++) begin
      if (squeeze && n == 30) hold_req <= 1'b1;
      case ($urandom_range(0, 9))
        0: cnt = 8'h00;
        1: cnt = 8'hFF;
        default: cnt = 8'($urandom_range(0, 255));
      endcase
      if ($urandom_range(0, 3) == 0) hdg = 16'($urandom_range(0, 65535));
      else hdg = 16'($urandom_range(0, 46079));
      // Back-to-back stretches, and a dense run while the output is held off.
      if ((squeeze && n >= 30 && n < 100) || (n / 40) % 3 == 2) gap = 0;
      else gap = pick_gap();
      offer_reading(4'($urandom_range(0, 15)), cnt, hdg, gap);
    end
  endtask

  initial begin : result_sink
    int stretch;
    int mode;
    bit held;
    held = 1'b0;
    result.ready <= 1'b0;
    forever begin
      stretch = $urandom_range(4, 40);
      mode    = $urandom_range(0, 9);
      repeat (stretch) begin
        @(posedge clk);
        if (hold_req && !held) begin
          held = 1'b1;
          result.ready <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk);
        end
        if (mode < 4) result.ready <= 1'b1;
        else if (mode < 7) result.ready <= ($urandom_range(0, 3) != 0);
        else if (mode < 9) result.ready <= 1'($urandom_range(0, 1));
        else result.ready <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (active) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("** detection_cone_endpoints_unit: FAILED **");
    $finish;
  end

  initial begin : stimulus
    int k;
    rst                  <= 1'b1;
    hold_req             <= 1'b0;
    psel                 <= 1'b0;
    penable              <= 1'b0;
    pwrite               <= 1'b0;
    paddr                <= '0;
    pwdata               <= '0;
    reading.valid        <= 1'b0;
    reading.sensor_index <= '0;
    reading.range_count  <= '0;
    reading.heading      <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Power-on settings: every sensor slot, including the quadrant boundaries.
    for (k = 0; k < 16; k++)
      offer_reading(k[3:0], 8'(k * 17), 16'd0, pick_gap());
    offer_reading(4'd0, 8'd100, 16'd46079, 0);
    // A heading of exactly one turn, and the largest raw heading, wrap around.
    offer_reading(4'd3, 8'd100, 16'd46080, 0);
    offer_reading(4'd15, 8'hFF, 16'hFFFF, pick_gap());
    offer_reading(4'd0, 8'd50, 16'd11519, 0);
    run_random(100, 1'b0);

    // Largest settings: long beams push the edge points into saturation.
    drain();
    load_settings(32'd1023, 32'd4095, 32'd65535);
    offer_reading(4'd0, 8'hFF, 16'd0, 0);
    offer_reading(4'd2, 8'hFF, 16'd0, 0);
    offer_reading(4'd10, 8'hFF, 16'd0, 0);
    offer_reading(4'd6, 8'hFF, 16'd0, 0);
    run_random(150, 1'b1);

    drain();
    load_settings(32'd0, 32'd0, 32'd0);
    apb_write(dce_tb_pkg::ADDR_UNMAPPED, $urandom());
    run_random(100, 1'b0);

    drain();
    load_settings(32'd1023, 32'd0, 32'd65535);
    run_random(125, 1'b0);

    // Unused upper data bits are random too.
    for (k = 0; k < 3; k++) begin
      drain();
      load_settings($urandom(), $urandom(), $urandom());
      run_random(125, 1'b0);
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("** detection_cone_endpoints_unit: PASSED **");
    end else begin
      $display("** detection_cone_endpoints_unit: FAILED **");
    end
    $finish;
  end

endmodule
